### hdl/region_page_allocator_top_defines.svh
// Assertion macros for the region page allocator.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef REGION_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define REGION_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define RPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("region page allocator assertion failed");
// Condition in one cycle forces a consequence in the next cycle.
`define RPA_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("region page allocator assertion failed");
`else
`define RPA_ASSERT(lbl, prop)
`define RPA_ASSERT_NEXT(lbl, cond, cons)
`endif
`endif

### hdl/rpa_pkg.sv
// Shared types and constants of the region page allocator.
// No dependencies.
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int FUNC_W   = 3;
  localparam int REGION_W = 6;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 3;
  localparam int PAGE_W   = 10;
  localparam int OFFSET_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH      = 3'd0,
    FN_POP       = 3'd1,
    FN_ALLOC     = 3'd2,
    FN_RESET     = 3'd3,
    FN_POP_UNTIL = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_PAGE = 3'd1,
    ST_FULL    = 3'd2,
    ST_BAD     = 3'd3,
    ST_LARGE   = 3'd4
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [REGION_W-1:0] region_handle;
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] word_offset;
  } res_t;

endpackage

### hdl/rpa_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on rpa_pkg.
`timescale 1ns / 1ps

interface rpa_in_if import rpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [REGION_W-1:0] region;
  logic [COUNT_W-1:0]  word_count;

  modport source (output valid, func, region, word_count, input ready);
  modport sink   (input valid, func, region, word_count, output ready);
endinterface

interface rpa_out_if import rpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [REGION_W-1:0] region_handle;
  logic [PAGE_W-1:0]   page;
  logic [OFFSET_W-1:0] word_offset;

  modport source (output valid, status, region_handle, page, word_offset, input ready);
  modport sink   (input valid, status, region_handle, page, word_offset, output ready);
endinterface

### hdl/rpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rpa_ctrl.sv
// Operation sequencer: reads, modifies and writes back the page link memory
// and the region memory. Depends on rpa_pkg and rpa_in_if.
`timescale 1ns / 1ps

module rpa_ctrl import rpa_pkg::*; #(
  parameter int NUM_PAGES   = 1024,
  parameter int PAGE_WORDS  = 254,
  parameter int MAX_REGIONS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rpa_in_if.sink                            in_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output res_t                              res_o,
  output logic                              pn_we_o,
  output logic [$clog2(NUM_PAGES)-1:0]      pn_waddr_o,
  output logic [$clog2(NUM_PAGES+1)-1:0]    pn_wdata_o,
  output logic [$clog2(NUM_PAGES)-1:0]      pn_raddr_o,
  input  logic [$clog2(NUM_PAGES+1)-1:0]    pn_rdata_i,
  output logic                              rg_we_o,
  output logic [$clog2(MAX_REGIONS)-1:0]    rg_waddr_o,
  output logic [2*$clog2(NUM_PAGES)+$clog2(PAGE_WORDS+1)-1:0] rg_wdata_o,
  output logic [$clog2(MAX_REGIONS)-1:0]    rg_raddr_o,
  input  logic [2*$clog2(NUM_PAGES)+$clog2(PAGE_WORDS+1)-1:0] rg_rdata_i
);

  localparam int PB   = $clog2(NUM_PAGES);
  localparam int NB   = $clog2(NUM_PAGES + 1);
  localparam int RB   = $clog2(MAX_REGIONS);
  localparam int CB   = $clog2(MAX_REGIONS + 1);
  localparam int OB   = $clog2(PAGE_WORDS + 1);
  localparam int SW   = ((OB > COUNT_W) ? OB : COUNT_W) + 1;
  localparam int CMPW = (CB > REGION_W) ? CB : REGION_W;
  localparam logic [NB-1:0] NULL_PG  = NB'(NUM_PAGES);
  localparam logic [SW-1:0] PW_LIMIT = SW'(PAGE_WORDS);
  localparam logic [CB-1:0] CNT_MAX  = CB'(MAX_REGIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PUSH, S_POP, S_AL_RD, S_AL_TAKE, S_AL_LINK,
    S_RS_RD, S_RS_NX, S_RS_CUT, S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [REGION_W-1:0]  reg_q, reg_d;
  logic [COUNT_W-1:0]   n_q, n_d;
  logic [NB-1:0]        fh_q, fh_d;
  logic [NB-1:0]        hw_q, hw_d;
  logic [CB-1:0]        cnt_q, cnt_d;
  logic [PB-1:0]        first_q, first_d;
  logic [PB-1:0]        last_q, last_d;
  logic [PB-1:0]        np_q, np_d;
  logic [PB-1:0]        pn_ra_q;
  res_t                 res_q, res_d;

  logic [NB-1:0]        pn_next;
  logic [PB-1:0]        rd_first, rd_last;
  logic [OB-1:0]        rd_off;
  logic [SW-1:0]        sum;
  logic                 r_valid;
  logic [RB-1:0]        top_idx;

  // Pages at or above the fill mark were never written and still hold
  // their reset link to the following page.
  assign pn_next = (NB'(pn_ra_q) >= hw_q) ? (NB'(pn_ra_q) + NB'(1)) : pn_rdata_i;

  assign rd_first = rg_rdata_i[2*PB+OB-1 -: PB];
  assign rd_last  = rg_rdata_i[PB+OB-1 -: PB];
  assign rd_off   = rg_rdata_i[OB-1:0];
  assign sum      = SW'(rd_off) + SW'(n_q);
  assign r_valid  = CMPW'(reg_q) < CMPW'(cnt_q);
  assign top_idx  = RB'(cnt_q - CB'(1));

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    reg_d   = reg_q;
    n_d     = n_q;
    fh_d    = fh_q;
    hw_d    = hw_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    last_d  = last_q;
    np_d    = np_q;
    res_d   = res_q;
    pn_we_o    = 1'b0;
    pn_waddr_o = '0;
    pn_wdata_o = '0;
    pn_raddr_o = fh_q[PB-1:0];
    rg_we_o    = 1'b0;
    rg_waddr_o = RB'(reg_q);
    rg_wdata_o = '0;
    rg_raddr_o = RB'(reg_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d  = in_i.func;
          reg_d   = in_i.region;
          n_d     = in_i.word_count;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d   = '0;
        state_d = S_DONE;
        unique case (func_q)
          FN_PUSH: begin
            if (cnt_q == CNT_MAX) begin
              res_d.status = ST_FULL;
            end else if (fh_q == NULL_PG) begin
              res_d.status = ST_NO_PAGE;
            end else begin
              state_d = S_PUSH;
            end
          end
          FN_POP: begin
            if (cnt_q == '0) begin
              res_d.status = ST_BAD;
            end else begin
              rg_raddr_o = top_idx;
              state_d    = S_POP;
            end
          end
          FN_ALLOC: begin
            if (!r_valid) begin
              res_d.status = ST_BAD;
            end else if (SW'(n_q) > PW_LIMIT) begin
              res_d.status = ST_LARGE;
            end else begin
              state_d = S_AL_RD;
            end
          end
          FN_RESET: begin
            if (!r_valid) begin
              res_d.status = ST_BAD;
            end else begin
              state_d = S_RS_RD;
            end
          end
          FN_POP_UNTIL: begin
            if (r_valid) begin
              rg_raddr_o = top_idx;
              state_d    = S_POP;
            end
          end
          default: begin
            res_d.status = ST_BAD;
          end
        endcase
      end
      S_PUSH: begin
        fh_d       = pn_next;
        pn_we_o    = 1'b1;
        pn_waddr_o = fh_q[PB-1:0];
        pn_wdata_o = NULL_PG;
        if (fh_q == hw_q) begin
          hw_d = hw_q + NB'(1);
        end
        rg_we_o    = 1'b1;
        rg_waddr_o = RB'(cnt_q);
        rg_wdata_o = {fh_q[PB-1:0], fh_q[PB-1:0], OB'(0)};
        res_d.region_handle = REGION_W'(cnt_q);
        cnt_d   = cnt_q + CB'(1);
        state_d = S_DONE;
      end
      S_POP: begin
        // Splice the whole chain of the top region in front of the free list.
        pn_we_o    = 1'b1;
        pn_waddr_o = rd_last;
        pn_wdata_o = fh_q;
        fh_d       = NB'(rd_first);
        cnt_d      = cnt_q - CB'(1);
        if (func_q == FN_POP_UNTIL && CMPW'(cnt_d) > CMPW'(reg_q)) begin
          rg_raddr_o = RB'(cnt_q - CB'(2));
        end else begin
          state_d = S_DONE;
        end
      end
      S_AL_RD: begin
        first_d = rd_first;
        last_d  = rd_last;
        state_d = S_DONE;
        if (sum > PW_LIMIT) begin
          if (fh_q == NULL_PG) begin
            res_d.status = ST_NO_PAGE;
          end else begin
            state_d = S_AL_TAKE;
          end
        end else begin
          rg_we_o    = 1'b1;
          rg_wdata_o = {rd_first, rd_last, OB'(sum)};
          res_d.page        = PAGE_W'(rd_last);
          res_d.word_offset = OFFSET_W'(rd_off);
        end
      end
      S_AL_TAKE: begin
        fh_d       = pn_next;
        np_d       = fh_q[PB-1:0];
        pn_we_o    = 1'b1;
        pn_waddr_o = fh_q[PB-1:0];
        pn_wdata_o = NULL_PG;
        if (fh_q == hw_q) begin
          hw_d = hw_q + NB'(1);
        end
        state_d = S_AL_LINK;
      end
      S_AL_LINK: begin
        pn_we_o    = 1'b1;
        pn_waddr_o = last_q;
        pn_wdata_o = NB'(np_q);
        rg_we_o    = 1'b1;
        rg_wdata_o = {first_q, np_q, OB'(n_q)};
        res_d.page = PAGE_W'(np_q);
        state_d    = S_DONE;
      end
      S_RS_RD: begin
        first_d    = rd_first;
        last_d     = rd_last;
        pn_raddr_o = rd_first;
        state_d    = S_RS_NX;
      end
      S_RS_NX: begin
        rg_we_o    = 1'b1;
        rg_wdata_o = {first_q, first_q, OB'(0)};
        state_d    = S_DONE;
        if (pn_next != NULL_PG) begin
          pn_we_o    = 1'b1;
          pn_waddr_o = last_q;
          pn_wdata_o = fh_q;
          fh_d       = pn_next;
          state_d    = S_RS_CUT;
        end
      end
      S_RS_CUT: begin
        pn_we_o    = 1'b1;
        pn_waddr_o = first_q;
        pn_wdata_o = NULL_PG;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fh_q    <= '0;
      hw_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
      hw_q    <= hw_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    reg_q   <= reg_d;
    n_q     <= n_d;
    first_q <= first_d;
    last_q  <= last_d;
    np_q    <= np_d;
    res_q   <= res_d;
    pn_ra_q <= pn_raddr_o;
  end

endmodule

### hdl/region_page_allocator_top.sv
// Region page allocator, top level: memories, sequencer and result register.
// Depends on rpa_pkg, rpa_if, rpa_ram, rpa_ctrl and the defines header.
`timescale 1ns / 1ps

// The allocator takes one request word at a time and returns exactly one
// result word for it. A request is accepted only while the sequencer is idle.
// After acceptance a dispatch step checks the request. A push or pop then takes
// a page from or returns a chain to the free list; an allocate reads the region
// and, if the object does not fit the current page, takes a fresh page and
// chains it; a region reset returns all but the first page of the region to
// the free list; a pop-until pops the named region and every region above it.
// Both memories have registered read data, and each step reads and then writes
// back. The result register lets the next request be accepted while the previous result
// still waits for the consumer. The page link memory needs no clearing pass:
// a fill mark records how many pages were ever handed out, and links of pages
// at or above it read as their reset value (the next page in order).

module region_page_allocator_top import rpa_pkg::*; #(
  parameter int NUM_PAGES   = 1024,
  parameter int PAGE_WORDS  = 254,
  parameter int MAX_REGIONS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpa_in_if.sink     in_i,
  rpa_out_if.source  out_o
);

`include "region_page_allocator_top_defines.svh"

  localparam int PB  = $clog2(NUM_PAGES);
  localparam int NB  = $clog2(NUM_PAGES + 1);
  localparam int RB  = $clog2(MAX_REGIONS);
  localparam int OB  = $clog2(PAGE_WORDS + 1);
  localparam int RGW = 2 * PB + OB;

  logic          pn_we;
  logic [PB-1:0] pn_waddr, pn_raddr;
  logic [NB-1:0] pn_wdata, pn_rdata;
  logic          rg_we;
  logic [RB-1:0] rg_waddr, rg_raddr;
  logic [RGW-1:0] rg_wdata, rg_rdata;

  logic res_valid, res_ready;
  res_t res;

  // Output register: holds the finished result word until it is taken.
  logic out_valid_q;
  res_t out_q;

  // Page link memory: next page of each page, null being NUM_PAGES.
  rpa_ram #(.WIDTH(NB), .DEPTH(NUM_PAGES)) u_page_next (
    .clk_i   (clk_i),
    .we_i    (pn_we),
    .waddr_i (pn_waddr),
    .wdata_i (pn_wdata),
    .raddr_i (pn_raddr),
    .rdata_o (pn_rdata)
  );

  // Region memory: first page, last page and bump offset of each region.
  rpa_ram #(.WIDTH(RGW), .DEPTH(MAX_REGIONS)) u_regions (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (rg_waddr),
    .wdata_i (rg_wdata),
    .raddr_i (rg_raddr),
    .rdata_o (rg_rdata)
  );

  rpa_ctrl #(
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_WORDS  (PAGE_WORDS),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .pn_we_o     (pn_we),
    .pn_waddr_o  (pn_waddr),
    .pn_wdata_o  (pn_wdata),
    .pn_raddr_o  (pn_raddr),
    .pn_rdata_i  (pn_rdata),
    .rg_we_o     (rg_we),
    .rg_waddr_o  (rg_waddr),
    .rg_wdata_o  (rg_wdata),
    .rg_raddr_o  (rg_raddr),
    .rg_rdata_i  (rg_rdata)
  );

  // The sequencer may hand over a result whenever the register is empty or
  // is being emptied in this cycle.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.region_handle = out_q.region_handle;
  assign out_o.page          = out_q.page;
  assign out_o.word_offset   = out_q.word_offset;

  // A request occupies the sequencer for at least the following cycle.
  `RPA_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  // A handed-over result always appears at the output in the next cycle.
  `RPA_ASSERT_NEXT(a_result_lands, res_valid && res_ready, out_o.valid)
  // A failed operation reports no page and no handle.
  `RPA_ASSERT(a_fail_clean, (res_valid && res.status != ST_OK) |-> (res.page == '0 && res.region_handle == '0))

endmodule
